// ===== hw/rtl/gha_pkg.sv =====
// shared types and codes for the generational handle allocator
// no dependencies; imported by gha_check, generational_handle_allocator and the testbench
`default_nettype none

package gha_pkg;

   localparam int IDX_OUT_W = 10;
   localparam int SER_OUT_W = 16;

   typedef enum logic [1:0] {
      REQ_CREATE   = 2'd0,
      REQ_REMOVE   = 2'd1,
      REQ_VALIDATE = 2'd2,
      REQ_UNUSED   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_UNUSED  = 2'd3
   } status_type;

   typedef struct packed {
      logic issued;
      logic valid;
   } chk_type;

endpackage

`default_nettype wire

// ===== hw/rtl/gha_ram.sv =====
// single-port-write, single-port-read synchronous ram with registered read data
// no dependencies; used for the serial table and the free index stack
`default_nettype none

module gha_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/gha_check.sv =====
// handle check: issued test, serial match and the bumped serial
// depends on gha_pkg
`default_nettype none

module gha_check #(
   parameter int MAX_ENTITIES = 1024,
   parameter int SERIAL_BITS  = 16
) (
   input  wire logic [gha_pkg::IDX_OUT_W-1:0]           index,
   input  wire logic [gha_pkg::SER_OUT_W-1:0]           serial,
   input  wire logic                                    owned,
   input  wire logic [$clog2(MAX_ENTITIES+1)-1:0]       issued_count,
   input  wire logic [SERIAL_BITS-1:0]                  stored,
   output gha_pkg::chk_type                             chk,
   output logic      [gha_pkg::SER_OUT_W-1:0]           stored_out,
   output logic      [SERIAL_BITS-1:0]                  next_serial,
   output logic      [gha_pkg::SER_OUT_W-1:0]           next_out
);
   import gha_pkg::*;

   localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
   localparam int CMP_IW = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;
   localparam int CMP_SW = (SERIAL_BITS > SER_OUT_W) ? SERIAL_BITS : SER_OUT_W;

   logic [CMP_IW-1:0]      index_ext;
   logic [CMP_IW-1:0]      issued_ext;
   logic [CMP_SW-1:0]      stored_ext;
   logic [CMP_SW-1:0]      serial_ext;
   logic [CMP_SW-1:0]      next_ext;
   logic [SERIAL_BITS-1:0] bumped;
   logic                   issued;

   assign index_ext  = CMP_IW'(index);
   assign issued_ext = CMP_IW'(issued_count);
   assign issued     = index_ext < issued_ext;

   // a never-issued index reads as serial zero
   assign stored_ext = issued ? CMP_SW'(stored) : '0;
   assign serial_ext = CMP_SW'(serial);

   assign chk.issued = issued;
   assign chk.valid  = owned && issued && (stored_ext == serial_ext);

   // wrap past the top, skipping the reserved zero serial
   assign bumped      = stored + 1'b1;
   assign next_serial = (bumped == '0) ? SERIAL_BITS'(1) : bumped;
   assign next_ext    = CMP_SW'(next_serial);

   assign stored_out = stored_ext[SER_OUT_W-1:0];
   assign next_out   = next_ext[SER_OUT_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/generational_handle_allocator.sv =====
// generational handle allocator top level: sequencer, counters, result register
// depends on gha_pkg, gha_ram and gha_check
//
// usage:
//   req_ channel takes one request word: req_type (create, remove, validate),
//   req_owned, req_entity_index and req_entity_serial. rsp_ channel returns
//   exactly one word per request: rsp_status, rsp_handle_index and
//   rsp_handle_serial. both channels use valid/ready.
// sequence:
//   validate, remove and a fresh create go from accept through the lookup
//   step into the result register. a create that reuses a freed index adds a
//   pop step, since the popped index must come out of the stack ram before
//   the serial ram can be read at it. one request is in flight at a time, so
//   a new word is accepted only once the last one has loaded its result.
// stall:
//   the result register holds a finished word; the next request is still
//   accepted and waits in its lookup or pop step until that word is taken.
// reset:
//   clears the issued and free counts and the handshakes. the rams need no
//   clearing: entries are used only below the issued or free count.
`default_nettype none

module generational_handle_allocator #(
   parameter int MAX_ENTITIES = 1024,
   parameter int SERIAL_BITS  = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_type,
   input  wire logic                              req_owned,
   input  wire logic [gha_pkg::IDX_OUT_W-1:0]     req_entity_index,
   input  wire logic [gha_pkg::SER_OUT_W-1:0]     req_entity_serial,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output gha_pkg::status_type                    rsp_status,
   output logic      [gha_pkg::IDX_OUT_W-1:0]     rsp_handle_index,
   output logic      [gha_pkg::SER_OUT_W-1:0]     rsp_handle_serial
);
   import gha_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ENTITIES);
   localparam int CNT_W  = $clog2(MAX_ENTITIES + 1);
   localparam int CMP_IW = (CNT_W > IDX_OUT_W) ? CNT_W : IDX_OUT_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_POP    = 3'b100
   } state_type;

   // sequencer and counters
   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        free_count_ff, free_count_in;
   logic [CNT_W-1:0]        issued_count_ff, issued_count_in;

   // latched request word
   logic [1:0]              type_ff;
   logic                    owned_ff;
   logic [IDX_OUT_W-1:0]    index_ff;
   logic [SER_OUT_W-1:0]    serial_ff;

   // result register
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [IDX_OUT_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [SER_OUT_W-1:0]    rsp_serial_ff, rsp_serial_in;

   // ram ports
   logic                    ser_wr_en, ser_rd_en;
   logic [IDX_W-1:0]        ser_wr_addr, ser_rd_addr;
   logic [SERIAL_BITS-1:0]  ser_wr_data, ser_rd_data;
   logic                    stk_wr_en;
   logic [IDX_W-1:0]        stk_wr_addr, stk_rd_addr;
   logic [IDX_W-1:0]        stk_rd_data;

   // check results
   chk_type                 chk;
   logic [SER_OUT_W-1:0]    stored_out;
   logic [SERIAL_BITS-1:0]  next_serial;
   logic [SER_OUT_W-1:0]    next_out;

   logic                    accept;
   logic                    out_free;
   logic                    is_create;
   logic                    is_remove;
   logic                    do_pop;
   logic                    fresh_ok;
   logic [CMP_IW-1:0]       req_idx_ext;
   logic [CMP_IW-1:0]       idx_ext;
   logic [CMP_IW-1:0]       issued_ext;
   logic [CMP_IW-1:0]       slot_ext;
   logic [CNT_W-1:0]        free_dec;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign is_create = (type_ff == REQ_CREATE);
   assign is_remove = (type_ff == REQ_REMOVE);
   assign do_pop    = is_create && (free_count_ff != '0);
   assign fresh_ok  = issued_count_ff < CNT_W'(MAX_ENTITIES);

   assign req_idx_ext = CMP_IW'(req_entity_index);
   assign idx_ext     = CMP_IW'(index_ff);
   assign issued_ext  = CMP_IW'(issued_count_ff);
   assign slot_ext    = CMP_IW'(stk_rd_data);
   assign free_dec    = free_count_ff - 1'b1;

   // reads: the handle's serial and the stack top on accept,
   // then the popped index's serial for a reusing create
   assign ser_rd_en   = accept || ((state_ff == ST_LOOKUP) && do_pop);
   assign ser_rd_addr = (state_ff == ST_IDLE) ? req_idx_ext[IDX_W-1:0] : stk_rd_data;
   assign stk_rd_addr = free_dec[IDX_W-1:0];

   gha_ram #(
      .DEPTH (MAX_ENTITIES),
      .WIDTH (SERIAL_BITS)
   ) u_serial_ram (
      .clock   (clock),
      .wr_en   (ser_wr_en),
      .wr_addr (ser_wr_addr),
      .wr_data (ser_wr_data),
      .rd_en   (ser_rd_en),
      .rd_addr (ser_rd_addr),
      .rd_data (ser_rd_data)
   );

   gha_ram #(
      .DEPTH (MAX_ENTITIES),
      .WIDTH (IDX_W)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (idx_ext[IDX_W-1:0]),
      .rd_en   (accept),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   gha_check #(
      .MAX_ENTITIES (MAX_ENTITIES),
      .SERIAL_BITS  (SERIAL_BITS)
   ) u_check (
      .index        (index_ff),
      .serial       (serial_ff),
      .owned        (owned_ff),
      .issued_count (issued_count_ff),
      .stored       (ser_rd_data),
      .chk          (chk),
      .stored_out   (stored_out),
      .next_serial  (next_serial),
      .next_out     (next_out)
   );

   always_comb begin
      state_in        = state_ff;
      free_count_in   = free_count_ff;
      issued_count_in = issued_count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_serial_in   = rsp_serial_ff;
      ser_wr_en       = 1'b0;
      ser_wr_addr     = idx_ext[IDX_W-1:0];
      ser_wr_data     = next_serial;
      stk_wr_en       = 1'b0;
      stk_wr_addr     = free_count_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (do_pop) begin
               // stack top is out; fetch its serial next
               state_in = ST_POP;
            end else if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (is_create) begin
                  if (fresh_ok) begin
                     // fresh index starts at serial one
                     ser_wr_en       = 1'b1;
                     ser_wr_addr     = issued_ext[IDX_W-1:0];
                     ser_wr_data     = SERIAL_BITS'(1);
                     issued_count_in = issued_count_ff + 1'b1;
                     rsp_status_in   = STATUS_OK;
                     rsp_index_in    = issued_ext[IDX_OUT_W-1:0];
                     rsp_serial_in   = SER_OUT_W'(1);
                  end else begin
                     rsp_status_in = STATUS_FULL;
                     rsp_index_in  = '0;
                     rsp_serial_in = '0;
                  end
               end else begin
                  rsp_index_in = index_ff;
                  if (!chk.valid) begin
                     rsp_status_in = STATUS_INVALID;
                     rsp_serial_in = stored_out;
                  end else if (is_remove) begin
                     // bump the serial and free the index
                     ser_wr_en     = 1'b1;
                     rsp_status_in = STATUS_OK;
                     rsp_serial_in = next_out;
                     if (free_count_ff < CNT_W'(MAX_ENTITIES)) begin
                        stk_wr_en     = 1'b1;
                        free_count_in = free_count_ff + 1'b1;
                     end
                  end else begin
                     rsp_status_in = STATUS_OK;
                     rsp_serial_in = stored_out;
                  end
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               free_count_in = free_dec;
               rsp_status_in = STATUS_OK;
               rsp_index_in  = slot_ext[IDX_OUT_W-1:0];
               rsp_serial_in = SER_OUT_W'(ser_rd_data);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         free_count_ff   <= '0;
         issued_count_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         free_count_ff   <= free_count_in;
         issued_count_ff <= issued_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // request word and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff   <= req_type;
         owned_ff  <= req_owned;
         index_ff  <= req_entity_index;
         serial_ff <= req_entity_serial;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_serial_ff <= rsp_serial_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_handle_index  = rsp_index_ff;
   assign rsp_handle_serial = rsp_serial_ff;

   // an accepted word always goes to the lookup step
   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted request did not enter lookup");

   // a new result only appears out of lookup or pop
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LOOKUP || $past(state_ff) == ST_POP)
      else $error("result loaded outside lookup or pop");

   // issued count only steps up by one
   a_issued_step: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && issued_count_ff != $past(issued_count_ff)
      |-> issued_count_ff == $past(issued_count_ff) + 1'b1)
      else $error("issued count moved by other than one");

   // counts stay within the table
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      issued_count_ff <= CNT_W'(MAX_ENTITIES) && free_count_ff <= CNT_W'(MAX_ENTITIES))
      else $error("count beyond table depth");

endmodule

`default_nettype wire

// ===== tb/sv/gha_handle_ledger.sv =====
// checker for the generational handle allocator: keeps its own serial table and free
// stack, predicts one word per accepted request and compares the rsp_ words in order
// depends on gha_pkg
`default_nettype none

module gha_handle_ledger (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_ready,
   input  wire logic [1:0]                     req_type,
   input  wire logic                           req_owned,
   input  wire logic [gha_pkg::IDX_OUT_W-1:0]  req_entity_index,
   input  wire logic [gha_pkg::SER_OUT_W-1:0]  req_entity_serial,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_ready,
   input  wire gha_pkg::status_type            rsp_status,
   input  wire logic [gha_pkg::IDX_OUT_W-1:0]  rsp_handle_index,
   input  wire logic [gha_pkg::SER_OUT_W-1:0]  rsp_handle_serial,
   output int                                  fail_count,
   output int                                  words_due
);
   import gha_pkg::*;

   localparam int ENTRIES = 1024;

   typedef struct packed {
      status_type            status;
      logic [IDX_OUT_W-1:0]  index;
      logic [SER_OUT_W-1:0]  serial;
   } handle_word_type;

   logic [SER_OUT_W-1:0] serial_mem [ENTRIES];
   logic [IDX_OUT_W-1:0] free_mem   [ENTRIES];
   int                   free_top;
   int                   issued_total;
   handle_word_type      due_words [$];

   function automatic handle_word_type predict_handle_word(
      input logic [1:0]           kind,
      input logic                 owned,
      input logic [IDX_OUT_W-1:0] index,
      input logic [SER_OUT_W-1:0] serial
   );
      handle_word_type      w;
      logic [IDX_OUT_W-1:0] slot;
      logic [SER_OUT_W-1:0] stored;
      logic [SER_OUT_W-1:0] bumped;
      logic                 issued;
      if (kind == REQ_CREATE) begin
         if (free_top > 0) begin
            // most recently freed index comes back with its bumped serial
            free_top--;
            slot = free_mem[free_top];
            w = '{STATUS_OK, slot, serial_mem[slot]};
         end else if (issued_total < ENTRIES) begin
            slot = IDX_OUT_W'(issued_total);
            serial_mem[slot] = SER_OUT_W'(1);
            issued_total++;
            w = '{STATUS_OK, slot, SER_OUT_W'(1)};
         end else begin
            w = '{STATUS_FULL, '0, '0};
         end
         return w;
      end
      // remove, validate and the unused code all check the handle first
      issued = int'(index) < issued_total;
      stored = issued ? serial_mem[index] : '0;
      if (!(owned && issued && stored == serial)) begin
         w = '{STATUS_INVALID, index, stored};
      end else if (kind == REQ_REMOVE) begin
         bumped = stored + SER_OUT_W'(1);
         if (bumped == '0) begin
            bumped = SER_OUT_W'(1);
         end
         serial_mem[index] = bumped;
         if (free_top < ENTRIES) begin
            free_mem[free_top] = index;
            free_top++;
         end
         w = '{STATUS_OK, index, bumped};
      end else begin
         w = '{STATUS_OK, index, stored};
      end
      return w;
   endfunction

   always @(posedge clock) begin
      handle_word_type want;
      handle_word_type next_word;
      if (reset) begin
         free_top     = 0;
         issued_total = 0;
         fail_count   = 0;
         due_words.delete();
      end else begin
         // a result cannot belong to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (due_words.size() == 0) begin
               $error("rsp word with no request pending: status %s index %0d serial %0d",
                      rsp_status.name(), rsp_handle_index, rsp_handle_serial);
               fail_count++;
            end else begin
               want = due_words.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status mismatch: expected %s, got %s",
                         want.status.name(), rsp_status.name());
                  fail_count++;
               end
               if (rsp_handle_index !== want.index) begin
                  $error("rsp_handle_index mismatch: expected %0d, got %0d",
                         want.index, rsp_handle_index);
                  fail_count++;
               end
               if (rsp_handle_serial !== want.serial) begin
                  $error("rsp_handle_serial mismatch: expected %0d, got %0d",
                         want.serial, rsp_handle_serial);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            next_word = predict_handle_word(req_type, req_owned,
                                            req_entity_index, req_entity_serial);
            due_words.insert(due_words.size(), next_word);
         end
      end
      words_due <= due_words.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/generational_handle_allocator_tb.sv =====
// top of the generational handle allocator testbench: clock, reset, request stimulus,
// rsp_ready stalls and the verdict; prediction and checking sit in gha_handle_ledger
// depends on gha_pkg, gha_handle_ledger and the allocator rtl
`default_nettype none

module generational_handle_allocator_tb;
   import gha_pkg::*;

   // a handle as the stimulus side knows it, learned from create results
   typedef struct {
      logic [IDX_OUT_W-1:0] index;
      logic [SER_OUT_W-1:0] serial;
   } ent_handle_type;

   logic                 clock;
   logic                 reset             = 1'b1;
   logic                 req_valid         = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_type          = REQ_CREATE;
   logic                 req_owned         = 1'b0;
   logic [IDX_OUT_W-1:0] req_entity_index  = '0;
   logic [SER_OUT_W-1:0] req_entity_serial = '0;
   logic                 rsp_valid;
   logic                 rsp_ready         = 1'b0;
   status_type           rsp_status;
   logic [IDX_OUT_W-1:0] rsp_handle_index;
   logic [SER_OUT_W-1:0] rsp_handle_serial;

   int  fail_count;
   int  words_due;

   // idle rates in percent, changed between phases
   int  req_idle_pct  = 7;
   int  rsp_stall_pct = 53;

   req_code_type   sent_kinds      [$];
   ent_handle_type live_handles    [$];
   ent_handle_type retired_handles [$];

   generational_handle_allocator u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_owned         (req_owned),
      .req_entity_index  (req_entity_index),
      .req_entity_serial (req_entity_serial),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_handle_index  (rsp_handle_index),
      .rsp_handle_serial (rsp_handle_serial)
   );

   gha_handle_ledger u_ledger (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_owned         (req_owned),
      .req_entity_index  (req_entity_index),
      .req_entity_serial (req_entity_serial),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_handle_index  (rsp_handle_index),
      .rsp_handle_serial (rsp_handle_serial),
      .fail_count        (fail_count),
      .words_due         (words_due)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver side: random stalls at the current rate
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
   end

   // learn handles from the result channel; sampled mid-cycle, where the
   // valid/ready pair already shows the handshake of the coming edge
   always @(negedge clock) begin
      ent_handle_type got;
      if (!reset && rsp_valid && rsp_ready && sent_kinds.size() != 0) begin
         if (sent_kinds.pop_front() == REQ_CREATE) begin
            if (rsp_status == STATUS_OK) begin
               got.index  = rsp_handle_index;
               got.serial = rsp_handle_serial;
               live_handles.insert(live_handles.size(), got);
            end
         end
      end
   end

   // one request word; valid stays high from word to word unless an idle gap
   // is drawn, so it never drops and rises within one step
   task automatic send_word(
      input req_code_type         kind,
      input logic                 owned,
      input logic [IDX_OUT_W-1:0] index,
      input logic [SER_OUT_W-1:0] serial
   );
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_owned         <= owned;
      req_entity_index  <= index;
      req_entity_serial <= serial;
      do @(posedge clock); while (!req_ready);
      sent_kinds.insert(sent_kinds.size(), kind);
   endtask

   // hold the sender until every expected word has come back or the wait limit
   // runs out, then let the block settle
   task automatic drain_words();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (words_due != 0 && waited < 20000);
      repeat (8) @(posedge clock);
   endtask

   // mostly well-formed traffic on handles the block gave out, plus stale
   // handles, foreign handles and plain noise
   task automatic random_request();
      int             pick;
      int             k;
      ent_handle_type h;
      logic           owned;
      req_code_type   kind;
      pick = $urandom_range(99);
      if (pick < 35 || (pick < 90 && live_handles.size() == 0)) begin
         // create ignores the handle fields, so fill them with anything
         send_word(REQ_CREATE, 1'($urandom_range(1)), IDX_OUT_W'($urandom),
                   SER_OUT_W'($urandom));
      end else if (pick < 60) begin
         // remove a live handle; its index comes back on a later create
         k = $urandom_range(live_handles.size() - 1);
         h = live_handles[k];
         live_handles.delete(k);
         retired_handles.insert(retired_handles.size(), h);
         send_word(REQ_REMOVE, 1'b1, h.index, h.serial);
      end else if (pick < 75) begin
         h    = live_handles[$urandom_range(live_handles.size() - 1)];
         kind = ($urandom_range(3) == 0) ? REQ_UNUSED : REQ_VALIDATE;
         send_word(kind, 1'b1, h.index, h.serial);
      end else if (pick < 90) begin
         // stale serial after a remove, or a live handle from another owner
         h     = live_handles[$urandom_range(live_handles.size() - 1)];
         owned = 1'b0;
         if (pick < 83 && retired_handles.size() != 0) begin
            h     = retired_handles[$urandom_range(retired_handles.size() - 1)];
            owned = 1'b1;
         end
         kind = ($urandom_range(1) == 0) ? REQ_REMOVE : REQ_VALIDATE;
         send_word(kind, owned, h.index, h.serial);
      end else begin
         send_word(req_code_type'($urandom_range(3)), 1'($urandom_range(1)),
                   IDX_OUT_W'($urandom), SER_OUT_W'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase one: sender idles rarely, receiver stalls often

      // nothing issued yet: every handle is unknown, including the top index
      send_word(REQ_VALIDATE, 1'b1, '0, '0);
      send_word(REQ_REMOVE, 1'b1, '0, SER_OUT_W'(1));
      send_word(REQ_UNUSED, 1'b1, '1, '1);
      // fresh indexes 0, 1, 2 with serial 1
      send_word(REQ_CREATE, 1'b1, '1, '1);
      send_word(REQ_CREATE, 1'b0, '0, '0);
      send_word(REQ_CREATE, 1'b1, '0, '1);
      send_word(REQ_VALIDATE, 1'b1, IDX_OUT_W'(1), SER_OUT_W'(1));
      // foreign owner, then wrong serial
      send_word(REQ_VALIDATE, 1'b0, IDX_OUT_W'(1), SER_OUT_W'(1));
      send_word(REQ_VALIDATE, 1'b1, IDX_OUT_W'(1), '1);
      // invalid remove leaves everything alone
      send_word(REQ_REMOVE, 1'b0, IDX_OUT_W'(1), SER_OUT_W'(1));
      send_word(REQ_REMOVE, 1'b1, IDX_OUT_W'(1), SER_OUT_W'(1));
      // the old serial is stale now
      send_word(REQ_REMOVE, 1'b1, IDX_OUT_W'(1), SER_OUT_W'(1));
      send_word(REQ_REMOVE, 1'b1, IDX_OUT_W'(2), SER_OUT_W'(1));
      // freed index answers with its bumped serial only
      send_word(REQ_VALIDATE, 1'b1, IDX_OUT_W'(2), SER_OUT_W'(2));
      // lifo reuse: index 2 first, then 1, then a fresh index 3
      send_word(REQ_CREATE, 1'b1, '0, '0);
      send_word(REQ_CREATE, 1'b1, '0, '0);
      send_word(REQ_CREATE, 1'b1, '0, '0);
      // the unused code behaves as validate
      send_word(REQ_UNUSED, 1'b1, '0, SER_OUT_W'(1));
      send_word(REQ_UNUSED, 1'b0, IDX_OUT_W'(2), SER_OUT_W'(2));
      send_word(REQ_VALIDATE, 1'b1, IDX_OUT_W'(3), SER_OUT_W'(1));
      // just past the issued range
      send_word(REQ_VALIDATE, 1'b1, IDX_OUT_W'(4), SER_OUT_W'(1));
      send_word(REQ_REMOVE, 1'b1, '1, '0);

      repeat (150) random_request();
      drain_words();

      // phase two: sender idles often, receiver stalls rarely
      req_idle_pct  = 53;
      rsp_stall_pct = 7;
      repeat (150) random_request();
      drain_words();

      // phase three: neither side idles
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      repeat (150) random_request();
      drain_words();

      // a word still owed after the drain limit counts as a failure
      if (fail_count == 0 && words_due == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // run limit, several times the slowest correct run
   initial begin
      #30_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

// ===== generational_handle_allocator.f =====
hw/rtl/gha_pkg.sv
hw/rtl/gha_ram.sv
hw/rtl/gha_check.sv
hw/rtl/generational_handle_allocator.sv
tb/sv/gha_handle_ledger.sv
tb/sv/generational_handle_allocator_tb.sv
